[src/mrwt_pkg.sv]
`default_nettype none
package mrwt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_RCHK,
    ST_SPLIT,
    ST_POW,
    ST_MUL_R,
    ST_POW_SQ,
    ST_MUL_B,
    ST_SQ_TEST,
    ST_SQ_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_STEP,
    OP_B_FROM_ACC,
    OP_SPLIT,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_WB_R,
    OP_WB_B,
    OP_WB_X
  } op_e;

  typedef enum logic [1:0] {
    SEL_RB,
    SEL_BB,
    SEL_XX
  } sel_e;

  typedef struct packed {
    op_e  op;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_is23;
    logic n_even;
    logic cnt_zero;
    logic acc_zero;
    logic acc_one;
    logic e_zero;
    logic e_lsb;
    logic s_zero;
    logic x_one;
    logic x_nm1;
  } sts_t;

endpackage
`default_nettype wire

[src/miller_rabin_witness_test.sv]
// One Miller-Rabin round per transaction on a candidate and a supplied witness.
// The input channel carries candidate_i and witness_i under in_valid_i/in_stall_o.
// The output channel carries composite_o under out_valid_o/out_stall_i.
// A transaction is taken when valid is high and stall is low.
// The block works on one transaction at a time; in_stall_o is high while busy.
// Every modular product uses one shared shift-add unit: a start, one step per bit
// of the multiplier, and a write-back unless the squaring loop ends on it.
// Trivial candidates (below 4 or even) get a verdict straight after the check. Otherwise
// the witness is reduced modulo the candidate bit by bit, the trailing zeros of the
// candidate minus one are split off, and each exponent bit costs one or two products.
// A full test needs up to about 2*NUM_WIDTH products.
// The finished verdict sits in an output register, so the block returns to idle
// and takes the next transaction while the receiver still stalls.
// If a second verdict is ready before the first one is taken, the block holds it
// and keeps in_stall_o high.
// Reset clears the controller and empties the output register.
`default_nettype none
module miller_rabin_witness_test #(
  parameter int unsigned NUM_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [NUM_WIDTH-1:0] candidate_i,
  input  wire logic [NUM_WIDTH-1:0] witness_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      composite_o
);

  mrwt_pkg::cmd_t cmd;
  mrwt_pkg::sts_t sts;

  mrwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .composite_o (composite_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrwt_datapath #(
    .W (NUM_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .candidate_i (candidate_i),
    .witness_i   (witness_i),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

[src/mrwt_datapath.sv]
`default_nettype none
module mrwt_datapath #(
  parameter int unsigned W = 64
) (
  input  wire logic          clk_i,
  input  wire mrwt_pkg::cmd_t cmd_i,
  input  wire logic [W-1:0]  candidate_i,
  input  wire logic [W-1:0]  witness_i,
  output mrwt_pkg::sts_t     sts_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  n_q, a_q, e_q, r_q, b_q, mx_q, my_q, acc_q;
  logic [CW-1:0] cnt_q, s_q;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] n);
    logic [W:0] s;
    begin
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, n}) begin
        s = s - {1'b0, n};
      end
      add_mod = s[W-1:0];
    end
  endfunction

  logic [W:0]   rem;
  logic [W-1:0] red_next, dbl, mul_next;

  always_comb begin
    rem = {acc_q, a_q[W-1]};
    if (rem >= {1'b0, n_q}) begin
      rem = rem - {1'b0, n_q};
    end
    red_next = rem[W-1:0];
    dbl = add_mod(acc_q, acc_q, n_q);
    mul_next = my_q[W-1] ? add_mod(dbl, mx_q, n_q) : dbl;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mrwt_pkg::OP_LOAD: begin
        n_q   <= candidate_i;
        a_q   <= witness_i;
        e_q   <= candidate_i - W'(1);
        s_q   <= '0;
        r_q   <= W'(1);
        acc_q <= '0;
        cnt_q <= CW'(W);
      end
      mrwt_pkg::OP_RED_STEP: begin
        acc_q <= red_next;
        a_q   <= {a_q[W-2:0], 1'b0};
        cnt_q <= cnt_q - CW'(1);
      end
      mrwt_pkg::OP_B_FROM_ACC: begin
        b_q <= acc_q;
      end
      mrwt_pkg::OP_SPLIT: begin
        e_q <= {1'b0, e_q[W-1:1]};
        s_q <= s_q + CW'(1);
      end
      mrwt_pkg::OP_MUL_START: begin
        case (cmd_i.sel)
          mrwt_pkg::SEL_RB: begin
            mx_q <= r_q;
            my_q <= b_q;
          end
          mrwt_pkg::SEL_BB: begin
            mx_q <= b_q;
            my_q <= b_q;
          end
          default: begin
            mx_q <= r_q;
            my_q <= r_q;
          end
        endcase
        acc_q <= '0;
        cnt_q <= CW'(W);
      end
      mrwt_pkg::OP_MUL_STEP: begin
        acc_q <= mul_next;
        my_q  <= {my_q[W-2:0], 1'b0};
        cnt_q <= cnt_q - CW'(1);
      end
      mrwt_pkg::OP_WB_R: begin
        r_q <= acc_q;
      end
      mrwt_pkg::OP_WB_B: begin
        b_q <= acc_q;
        e_q <= {1'b0, e_q[W-1:1]};
      end
      mrwt_pkg::OP_WB_X: begin
        r_q <= acc_q;
        s_q <= s_q - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o.n_lt2    = (n_q[W-1:1] == '0);
    sts_o.n_is23   = (n_q[W-1:2] == '0) && n_q[1];
    sts_o.n_even   = !n_q[0];
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.acc_zero = (acc_q == '0);
    sts_o.acc_one  = (acc_q == W'(1));
    sts_o.e_zero   = (e_q == '0);
    sts_o.e_lsb    = e_q[0];
    sts_o.s_zero   = (s_q == '0);
    sts_o.x_one    = (r_q == W'(1));
    sts_o.x_nm1    = (r_q == n_q - W'(1));
  end

endmodule
`default_nettype wire

[src/mrwt_ctrl.sv]
`default_nettype none
module mrwt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                composite_o,
  input  wire mrwt_pkg::sts_t sts_i,
  output mrwt_pkg::cmd_t      cmd_o
);

  mrwt_pkg::state_e state_q, state_d;
  logic verdict_q, verdict_d;
  logic out_valid_q, out_valid_d;
  logic composite_q, composite_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrwt_pkg::ST_IDLE;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
      composite_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
      composite_q <= composite_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    composite_d = composite_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = mrwt_pkg::OP_NONE;
    cmd_o.sel   = mrwt_pkg::SEL_RB;
    in_stall_o  = (state_q != mrwt_pkg::ST_IDLE);
    case (state_q)
      mrwt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mrwt_pkg::OP_LOAD;
          state_d  = mrwt_pkg::ST_CHECK;
        end
      end
      mrwt_pkg::ST_CHECK: begin
        if (sts_i.n_lt2) begin
          verdict_d = 1'b1;
          state_d   = mrwt_pkg::ST_DONE;
        end else if (sts_i.n_is23) begin
          verdict_d = 1'b0;
          state_d   = mrwt_pkg::ST_DONE;
        end else if (sts_i.n_even) begin
          verdict_d = 1'b1;
          state_d   = mrwt_pkg::ST_DONE;
        end else begin
          state_d = mrwt_pkg::ST_REDUCE;
        end
      end
      mrwt_pkg::ST_REDUCE: begin
        if (!sts_i.cnt_zero) begin
          cmd_o.op = mrwt_pkg::OP_RED_STEP;
        end else begin
          state_d = mrwt_pkg::ST_RCHK;
        end
      end
      mrwt_pkg::ST_RCHK: begin
        if (sts_i.acc_zero) begin
          verdict_d = 1'b0;
          state_d   = mrwt_pkg::ST_DONE;
        end else begin
          cmd_o.op = mrwt_pkg::OP_B_FROM_ACC;
          state_d  = mrwt_pkg::ST_SPLIT;
        end
      end
      mrwt_pkg::ST_SPLIT: begin
        if (!sts_i.e_lsb) begin
          cmd_o.op = mrwt_pkg::OP_SPLIT;
        end else begin
          state_d = mrwt_pkg::ST_POW;
        end
      end
      mrwt_pkg::ST_POW: begin
        if (sts_i.e_zero) begin
          state_d = mrwt_pkg::ST_SQ_TEST;
        end else if (sts_i.e_lsb) begin
          cmd_o.op  = mrwt_pkg::OP_MUL_START;
          cmd_o.sel = mrwt_pkg::SEL_RB;
          state_d   = mrwt_pkg::ST_MUL_R;
        end else begin
          state_d = mrwt_pkg::ST_POW_SQ;
        end
      end
      mrwt_pkg::ST_MUL_R: begin
        if (!sts_i.cnt_zero) begin
          cmd_o.op = mrwt_pkg::OP_MUL_STEP;
        end else begin
          cmd_o.op = mrwt_pkg::OP_WB_R;
          state_d  = mrwt_pkg::ST_POW_SQ;
        end
      end
      mrwt_pkg::ST_POW_SQ: begin
        cmd_o.op  = mrwt_pkg::OP_MUL_START;
        cmd_o.sel = mrwt_pkg::SEL_BB;
        state_d   = mrwt_pkg::ST_MUL_B;
      end
      mrwt_pkg::ST_MUL_B: begin
        if (!sts_i.cnt_zero) begin
          cmd_o.op = mrwt_pkg::OP_MUL_STEP;
        end else begin
          cmd_o.op = mrwt_pkg::OP_WB_B;
          state_d  = mrwt_pkg::ST_POW;
        end
      end
      mrwt_pkg::ST_SQ_TEST: begin
        if (sts_i.s_zero || sts_i.x_one) begin
          verdict_d = !sts_i.x_one;
          state_d   = mrwt_pkg::ST_DONE;
        end else begin
          cmd_o.op  = mrwt_pkg::OP_MUL_START;
          cmd_o.sel = mrwt_pkg::SEL_XX;
          state_d   = mrwt_pkg::ST_SQ_MUL;
        end
      end
      mrwt_pkg::ST_SQ_MUL: begin
        if (!sts_i.cnt_zero) begin
          cmd_o.op = mrwt_pkg::OP_MUL_STEP;
        end else if (!sts_i.x_nm1 && sts_i.acc_one) begin
          verdict_d = 1'b1;
          state_d   = mrwt_pkg::ST_DONE;
        end else begin
          cmd_o.op = mrwt_pkg::OP_WB_X;
          state_d  = mrwt_pkg::ST_SQ_TEST;
        end
      end
      mrwt_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          composite_d = verdict_q;
          state_d     = mrwt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mrwt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign composite_o = composite_q;

endmodule
`default_nettype wire

[src/mrwt_checker.sv]
`default_nettype none
module mrwt_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic composite_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block did not go busy after taking a transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("Block went idle without presenting a verdict.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled verdict was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(composite_o))
    else $error("Stalled verdict changed.");

endmodule

bind miller_rabin_witness_test mrwt_checker u_mrwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .composite_o (composite_o)
);
`default_nettype wire
